### rtl/core/quadrant_block_quantizer_defines.svh
// Assertion macros shared by the quadrant block quantizer RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef QUADRANT_BLOCK_QUANTIZER_DEFINES_SVH
`define QUADRANT_BLOCK_QUANTIZER_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define QBQ_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("quantizer same-cycle check failed");

// Next-cycle implication, checked only outside reset.
`define QBQ_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("quantizer next-cycle check failed");

`endif

### rtl/core/qbq_pkg.sv
// Package for the quadrant block quantizer: types, constants and helper functions.
// No dependencies; used by the channel interfaces and all modules.
`timescale 1ns / 1ps

package qbq_pkg;

    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 32;
    localparam int NUM_PIX    = 4;
    localparam int NUM_PAIRS  = 6;
    localparam int MASK_W     = 4;
    localparam int GLYPH_W    = 14;
    localparam int CFG_IDX_W  = 2;
    // 3 * 255^2 fits in 18 bits, as does 1000 * 255.
    localparam int DIST_W     = 18;
    localparam int LSUM_W     = 18;

    localparam int LUMA_R     = 299;
    localparam int LUMA_G     = 587;
    localparam int LUMA_B     = 114;
    localparam int LUMA_DIV   = 1000;
    localparam int LUMA_SHIFT = 28;
    localparam int LUMA_RECIP_W = 19;
    localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP =
        LUMA_RECIP_W'((64'd1 << LUMA_SHIFT) / LUMA_DIV + 64'd1);
    localparam int LPROD_W    = LSUM_W + LUMA_RECIP_W;

    localparam logic [MASK_W-1:0] PATTERN_FULL = 4'hF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_BLUE  = 2'd2;

    typedef logic [1:0]          pix_idx_t;
    typedef logic [2:0]          pair_idx_t;
    typedef logic [DIST_W-1:0]   dist_t;
    typedef logic [LSUM_W-1:0]   lsum_t;
    typedef logic [CHAN_W-1:0]   luma_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } color_t;

    localparam pix_idx_t PAIR_A [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam pix_idx_t PAIR_B [NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

    // Position of the unordered pair {i, j} in the 01,02,03,12,13,23 order.
    function automatic pair_idx_t pair_index(input pix_idx_t i, input pix_idx_t j);
        pix_idx_t lo;
        pix_idx_t hi;
        pair_idx_t idx;
        lo = (i < j) ? i : j;
        hi = (i < j) ? j : i;
        case ({lo, hi})
            4'b0001: idx = 3'd0;
            4'b0010: idx = 3'd1;
            4'b0011: idx = 3'd2;
            4'b0110: idx = 3'd3;
            4'b0111: idx = 3'd4;
            4'b1011: idx = 3'd5;
            default: idx = 3'd0;
        endcase
        return idx;
    endfunction

    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [MASK_W-1:0] pat);
        logic [GLYPH_W-1:0] code;
        case (pat)
            4'h0: code = 14'h0020;
            4'h1: code = 14'h2598;
            4'h2: code = 14'h259D;
            4'h3: code = 14'h2580;
            4'h4: code = 14'h2596;
            4'h5: code = 14'h258C;
            4'h6: code = 14'h259E;
            4'h7: code = 14'h259B;
            4'h8: code = 14'h2597;
            4'h9: code = 14'h259A;
            4'hA: code = 14'h2590;
            4'hB: code = 14'h259C;
            4'hC: code = 14'h2584;
            4'hD: code = 14'h2599;
            4'hE: code = 14'h259F;
            default: code = 14'h2588;
        endcase
        return code;
    endfunction

endpackage

### rtl/core/qbq_if.sv
// Channel interfaces of the quadrant block quantizer: tile input, cell output, config writes.
// Depends on qbq_pkg for field widths.
`timescale 1ns / 1ps

interface qbq_tile_if import qbq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  pix_top_left;
    logic [PIX_W-1:0]  pix_top_right;
    logic [PIX_W-1:0]  pix_bottom_left;
    logic [PIX_W-1:0]  pix_bottom_right;
    logic [MASK_W-1:0] inside_mask;

    modport source (output valid, pix_top_left, pix_top_right, pix_bottom_left,
                    pix_bottom_right, inside_mask, input ready);
    modport sink   (input valid, pix_top_left, pix_top_right, pix_bottom_left,
                    pix_bottom_right, inside_mask, output ready);
endinterface

interface qbq_cell_if import qbq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MASK_W-1:0]  pattern;
    logic [GLYPH_W-1:0] glyph_code;
    logic [CHAN_W-1:0]  ink_red;
    logic [CHAN_W-1:0]  ink_green;
    logic [CHAN_W-1:0]  ink_blue;
    logic [CHAN_W-1:0]  paper_red;
    logic [CHAN_W-1:0]  paper_green;
    logic [CHAN_W-1:0]  paper_blue;

    modport source (output valid, pattern, glyph_code, ink_red, ink_green, ink_blue,
                    paper_red, paper_green, paper_blue, input ready);
    modport sink   (input valid, pattern, glyph_code, ink_red, ink_green, ink_blue,
                    paper_red, paper_green, paper_blue, output ready);
endinterface

interface qbq_cfg_if import qbq_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CHAN_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/qbq_metrics.sv
// Pair metrics of a tile: six squared RGB distances and four unscaled luma sums.
// Depends on qbq_pkg.
`timescale 1ns / 1ps

module qbq_metrics import qbq_pkg::*; (
    input  color_t cols      [NUM_PIX],
    output dist_t  pair_dist [NUM_PAIRS],
    output lsum_t  luma_sum  [NUM_PIX]
);

    function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] x,
                                                    input logic [CHAN_W-1:0] y);
        logic [CHAN_W-1:0] d;
        d = (x >= y) ? (x - y) : (y - x);
        return d * d;
    endfunction

    always_comb
    begin
        for (int k = 0; k < NUM_PAIRS; k++)
        begin
            pair_dist[k] = DIST_W'(sq_diff(cols[PAIR_A[k]].red,   cols[PAIR_B[k]].red))
                         + DIST_W'(sq_diff(cols[PAIR_A[k]].green, cols[PAIR_B[k]].green))
                         + DIST_W'(sq_diff(cols[PAIR_A[k]].blue,  cols[PAIR_B[k]].blue));
        end
        for (int i = 0; i < NUM_PIX; i++)
        begin
            luma_sum[i] = LSUM_W'(LUMA_R) * LSUM_W'(cols[i].red)
                        + LSUM_W'(LUMA_G) * LSUM_W'(cols[i].green)
                        + LSUM_W'(LUMA_B) * LSUM_W'(cols[i].blue);
        end
    end

endmodule

### rtl/core/quadrant_block_quantizer.sv
// Top level of the quadrant block quantizer: fill registers and a four-stage pipeline.
// Depends on qbq_pkg, the channel interfaces in qbq_if and qbq_metrics.
//
// Usage: a 2x2 RGBA tile and its inside mask arrive as one request on the tile
// channel; one cell (pattern, glyph code point, ink and paper colors) leaves as
// one request on the glyph_cell channel. The cfg channel writes the fill color,
// index 0 red, 1 green, 2 blue; other indexes are ignored and cfg is always ready.
// Write it only while the pipeline is empty.
// The four
// register stages are fill substitution (loaded at the acceptance edge), distance
// and luma sums, pair choice with luma division, then pattern and color
// assignment into the output register.
// Throughput: one tile per cycle while the receiver takes cells, set by the fully pipelined datapath.
// Reset clears all stage valid bits and the fill color to black.
// When the receiver stalls, stages hold their contents; tile ready stays high
// while some stage ahead is empty, so bubbles are squeezed out.
`timescale 1ns / 1ps
`include "quadrant_block_quantizer_defines.svh"

module quadrant_block_quantizer import qbq_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    qbq_cfg_if.sink     cfg,
    qbq_tile_if.sink    tile,
    qbq_cell_if.source  glyph_cell
);

    color_t fill_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ready1, ready2, ready3, ready4;

    color_t   s1_col_reg  [NUM_PIX];
    color_t   s2_col_reg  [NUM_PIX];
    dist_t    s2_dist_reg [NUM_PAIRS];
    lsum_t    s2_lsum_reg [NUM_PIX];
    color_t   s3_col_reg  [NUM_PIX];
    dist_t    s3_dist_reg [NUM_PAIRS];
    luma_t    s3_luma_reg [NUM_PIX];
    pix_idx_t s3_a_reg, s3_b_reg;

    logic [MASK_W-1:0]  pattern_reg;
    logic [GLYPH_W-1:0] glyph_reg;
    color_t             ink_reg, paper_reg;

    color_t             s1_col_next [NUM_PIX];
    dist_t              dist_w      [NUM_PAIRS];
    lsum_t              lsum_w      [NUM_PIX];
    luma_t              luma_next   [NUM_PIX];
    pix_idx_t           a_next, b_next;
    logic [MASK_W-1:0]  pattern_next;
    color_t             ink_next, paper_next;

    // Configuration writes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_FILL_RED:   fill_reg.red   <= cfg.data;
                CFG_FILL_GREEN: fill_reg.green <= cfg.data;
                CFG_FILL_BLUE:  fill_reg.blue  <= cfg.data;
                default: ;
            endcase
        end
    end

    // Handshake chain: a stage may load when it is empty or the next one loads.
    assign ready4     = !v4_reg || glyph_cell.ready;
    assign ready3     = !v3_reg || ready4;
    assign ready2     = !v2_reg || ready3;
    assign ready1     = !v1_reg || ready2;
    assign tile.ready = ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready1) v1_reg <= tile.valid;
            if (ready2) v2_reg <= v1_reg;
            if (ready3) v3_reg <= v2_reg;
            if (ready4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: substitute the fill color for off-image or fully transparent pixels.
    always_comb
    begin
        logic [PIX_W-1:0] pix [NUM_PIX];
        pix[0] = tile.pix_top_left;
        pix[1] = tile.pix_top_right;
        pix[2] = tile.pix_bottom_left;
        pix[3] = tile.pix_bottom_right;
        for (int i = 0; i < NUM_PIX; i++)
        begin
            if (tile.inside_mask[i] && (pix[i][31:24] != '0))
            begin
                s1_col_next[i].red   = pix[i][7:0];
                s1_col_next[i].green = pix[i][15:8];
                s1_col_next[i].blue  = pix[i][23:16];
            end
            else
            begin
                s1_col_next[i] = fill_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && tile.valid)
            s1_col_reg <= s1_col_next;
    end

    // Stage 2: distances and luma sums.
    qbq_metrics u_metrics (
        .cols      (s1_col_reg),
        .pair_dist (dist_w),
        .luma_sum  (lsum_w)
    );

    always_ff @(posedge clk)
    begin
        if (ready2 && v1_reg)
        begin
            s2_col_reg  <= s1_col_reg;
            s2_dist_reg <= dist_w;
            s2_lsum_reg <= lsum_w;
        end
    end

    // Stage 3: farthest pair (first strict maximum) and luma / 1000 by reciprocal.
    always_comb
    begin
        dist_t best;
        logic [LPROD_W-1:0] prod;
        best   = s2_dist_reg[0];
        a_next = PAIR_A[0];
        b_next = PAIR_B[0];
        for (int k = 1; k < NUM_PAIRS; k++)
        begin
            if (s2_dist_reg[k] > best)
            begin
                best   = s2_dist_reg[k];
                a_next = PAIR_A[k];
                b_next = PAIR_B[k];
            end
        end
        for (int i = 0; i < NUM_PIX; i++)
        begin
            prod = LPROD_W'(s2_lsum_reg[i]) * LPROD_W'(LUMA_RECIP);
            luma_next[i] = prod[LUMA_SHIFT +: CHAN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && v2_reg)
        begin
            s3_col_reg  <= s2_col_reg;
            s3_dist_reg <= s2_dist_reg;
            s3_luma_reg <= luma_next;
            s3_a_reg    <= a_next;
            s3_b_reg    <= b_next;
        end
    end

    // Stage 4: nearest-representative pattern, ink and paper selection.
    always_comb
    begin
        dist_t da, db;
        logic [MASK_W-1:0] pat;
        for (int i = 0; i < NUM_PIX; i++)
        begin
            da = (pix_idx_t'(i) == s3_a_reg) ? '0
               : s3_dist_reg[pair_index(pix_idx_t'(i), s3_a_reg)];
            db = (pix_idx_t'(i) == s3_b_reg) ? '0
               : s3_dist_reg[pair_index(pix_idx_t'(i), s3_b_reg)];
            pat[i] = (da <= db);
        end
        if (s3_luma_reg[s3_a_reg] <= s3_luma_reg[s3_b_reg])
        begin
            ink_next     = s3_col_reg[s3_a_reg];
            paper_next   = s3_col_reg[s3_b_reg];
            pattern_next = pat;
        end
        else
        begin
            ink_next     = s3_col_reg[s3_b_reg];
            paper_next   = s3_col_reg[s3_a_reg];
            pattern_next = ~pat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready4 && v3_reg)
        begin
            pattern_reg <= pattern_next;
            glyph_reg   <= glyph_of(pattern_next);
            ink_reg     <= ink_next;
            paper_reg   <= paper_next;
        end
    end

    assign glyph_cell.valid       = v4_reg;
    assign glyph_cell.pattern     = pattern_reg;
    assign glyph_cell.glyph_code  = glyph_reg;
    assign glyph_cell.ink_red     = ink_reg.red;
    assign glyph_cell.ink_green   = ink_reg.green;
    assign glyph_cell.ink_blue    = ink_reg.blue;
    assign glyph_cell.paper_red   = paper_reg.red;
    assign glyph_cell.paper_green = paper_reg.green;
    assign glyph_cell.paper_blue  = paper_reg.blue;

    // The glyph register must track the pattern register.
    `QBQ_ASSERT_NOW(a_glyph_matches, v4_reg, glyph_reg == glyph_of(pattern_reg))
    // Identical ink and paper means a uniform tile, which shows the full block.
    `QBQ_ASSERT_NOW(a_uniform_full, v4_reg && (ink_reg == paper_reg),
                    pattern_reg == PATTERN_FULL)
    // The chosen pair is always ordered and distinct.
    `QBQ_ASSERT_NOW(a_pair_ordered, v3_reg, s3_a_reg < s3_b_reg)
    // A stage blocked by the one ahead keeps its item.
    `QBQ_ASSERT_NEXT(a_stage3_holds, v3_reg && !ready4, v3_reg)

endmodule

### test/tb_quadrant_block_quantizer.sv
// Self-checking testbench for quadrant_block_quantizer: random and directed 2x2 tiles,
// predicted cells compared field by field. Depends on qbq_pkg, qbq_if and the RTL top.
`timescale 1ns / 1ps

module tb_quadrant_block_quantizer;
    import qbq_pkg::*;

    localparam int PIPE_LATENCY   = 4;
    localparam int TIMEOUT_NS     = 5_000_000;
    localparam int CHUNK_TILES    = 325;
    localparam int NUM_CHUNKS     = 6;
    localparam int HOLD_CYCLES    = 250;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [MASK_W-1:0]    MASK_ALL   = {MASK_W{1'b1}};

    localparam logic [GLYPH_W-1:0] QUADRANT_GLYPHS [16] = '{
        14'h0020, 14'h2598, 14'h259D, 14'h2580, 14'h2596, 14'h258C, 14'h259E, 14'h259B,
        14'h2597, 14'h259A, 14'h2590, 14'h259C, 14'h2584, 14'h2599, 14'h259F, 14'h2588
    };

    typedef struct packed {
        logic [PIX_W-1:0]  top_left;
        logic [PIX_W-1:0]  top_right;
        logic [PIX_W-1:0]  bottom_left;
        logic [PIX_W-1:0]  bottom_right;
        logic [MASK_W-1:0] mask;
    } tile_t;

    typedef struct packed {
        logic [MASK_W-1:0]  pattern;
        logic [GLYPH_W-1:0] glyph;
        color_t             ink;
        color_t             paper;
    } cell_t;

    logic clk;
    logic rst_n;

    qbq_cfg_if  cfg_if ();
    qbq_tile_if tile_if ();
    qbq_cell_if cell_if ();

    quadrant_block_quantizer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_if),
        .tile       (tile_if),
        .glyph_cell (cell_if)
    );

    tile_t  pending_tiles [$];
    cell_t  expected_cells [$];
    tile_t  next_tile;
    cell_t  oldest_cell;
    color_t fill_color = '0;
    int     tiles_accepted = 0;
    int     errors = 0;
    int     sender_idle_pct = 15;
    int     receiver_idle_pct = 46;
    logic   receiver_hold = 1'b0;

    function automatic int color_dist(input color_t a, input color_t b);
        int dr;
        int dg;
        int db;
        dr = int'(a.red) - int'(b.red);
        dg = int'(a.green) - int'(b.green);
        db = int'(a.blue) - int'(b.blue);
        return dr * dr + dg * dg + db * db;
    endfunction

    function automatic int luma_of(input color_t c);
        return (LUMA_R * int'(c.red) + LUMA_G * int'(c.green) + LUMA_B * int'(c.blue))
               / LUMA_DIV;
    endfunction

    // Builds the cell that the block must return for one tile under the given fill.
    function automatic cell_t quantize_tile(input tile_t t, input color_t fill);
        logic [PIX_W-1:0]  raw [NUM_PIX];
        color_t            px [NUM_PIX];
        int                best;
        int                d;
        int                a;
        int                b;
        int                i;
        int                j;
        logic [MASK_W-1:0] pat;
        cell_t             c;
        raw[0] = t.top_left;
        raw[1] = t.top_right;
        raw[2] = t.bottom_left;
        raw[3] = t.bottom_right;
        for (i = 0; i < NUM_PIX; i++)
        begin
            if (t.mask[i] && raw[i][31:24] != 8'h00)
            begin
                px[i].red   = raw[i][7:0];
                px[i].green = raw[i][15:8];
                px[i].blue  = raw[i][23:16];
            end
            else
                px[i] = fill;
        end
        // Pair 01 wins unless a later pair is strictly farther apart.
        a = 0;
        b = 1;
        best = color_dist(px[0], px[1]);
        for (i = 0; i < NUM_PIX; i++)
            for (j = i + 1; j < NUM_PIX; j++)
            begin
                d = color_dist(px[i], px[j]);
                if (d > best)
                begin
                    best = d;
                    a = i;
                    b = j;
                end
            end
        pat = '0;
        for (i = 0; i < NUM_PIX; i++)
            if (color_dist(px[i], px[a]) <= color_dist(px[i], px[b]))
                pat[i] = 1'b1;
        if (luma_of(px[a]) <= luma_of(px[b]))
        begin
            c.ink = px[a];
            c.paper = px[b];
        end
        else
        begin
            c.ink = px[b];
            c.paper = px[a];
            pat = ~pat;
        end
        c.pattern = pat;
        c.glyph = QUADRANT_GLYPHS[pat];
        return c;
    endfunction

    function automatic logic [PIX_W-1:0] opaque(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
        return {8'hFF, b, g, r};
    endfunction

    // Mixes free colors with small palettes, so that ties and uniform tiles are common.
    function automatic tile_t random_tile();
        color_t           palette [4];
        logic [PIX_W-1:0] p [NUM_PIX];
        logic [7:0]       alpha;
        color_t           c;
        int               style;
        int               i;
        tile_t            t;
        for (i = 0; i < 4; i++)
            palette[i] = color_t'($urandom);
        style = $urandom_range(3);
        for (i = 0; i < NUM_PIX; i++)
        begin
            case (style)
                0: c = color_t'($urandom);
                1: c = palette[$urandom_range(1)];
                2: c = palette[$urandom_range(3)];
                default:
                begin
                    c.red   = $urandom_range(1) ? 8'hFF : 8'h00;
                    c.green = $urandom_range(1) ? 8'hFF : 8'h00;
                    c.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
                end
            endcase
            alpha = ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom);
            p[i] = {alpha, c.blue, c.green, c.red};
        end
        t.top_left = p[0];
        t.top_right = p[1];
        t.bottom_left = p[2];
        t.bottom_right = p[3];
        t.mask = $urandom_range(1) ? MASK_ALL : MASK_W'($urandom);
        return t;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Writes the fill color; optionally also an unmapped index, which must be ignored.
    task automatic write_fill(input color_t c, input bit add_unused);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CHAN_W-1:0]    vals [4];
        int                   n;
        int                   k;
        idx = '{CFG_FILL_RED, CFG_FILL_GREEN, CFG_FILL_BLUE, CFG_UNUSED};
        vals = '{c.red, c.green, c.blue, 8'($urandom)};
        n = add_unused ? 4 : 3;
        @(posedge clk);
        for (k = 0; k < n; k++)
        begin
            cfg_if.index <= idx[k];
            cfg_if.data <= vals[k];
            cfg_if.valid <= 1'b1;
            do @(posedge clk); while (cfg_if.ready !== 1'b1);
            case (idx[k])
                CFG_FILL_RED:   fill_color.red = vals[k];
                CFG_FILL_GREEN: fill_color.green = vals[k];
                CFG_FILL_BLUE:  fill_color.blue = vals[k];
                default: ;
            endcase
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (pending_tiles.size() != 0 || tile_if.valid || expected_cells.size() != 0);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        tile_if.valid = 1'b0;
        tile_if.pix_top_left = '0;
        tile_if.pix_top_right = '0;
        tile_if.pix_bottom_left = '0;
        tile_if.pix_bottom_right = '0;
        tile_if.inside_mask = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        cell_if.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    // Long receiver stall while the sender keeps offering, so the pipeline backs up.
    initial
    begin
        @(posedge rst_n);
        while (tiles_accepted < 150)
            @(posedge clk);
        receiver_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        receiver_hold <= 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tile_if.valid <= 1'b0;
        else
        begin
            if (tile_if.valid && tile_if.ready)
            begin
                expected_cells.push_back(quantize_tile('{tile_if.pix_top_left,
                    tile_if.pix_top_right, tile_if.pix_bottom_left, tile_if.pix_bottom_right,
                    tile_if.inside_mask}, fill_color));
                tiles_accepted <= tiles_accepted + 1;
            end
            if (!tile_if.valid || tile_if.ready)
            begin
                if (pending_tiles.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_tile = pending_tiles.pop_front();
                    tile_if.pix_top_left <= next_tile.top_left;
                    tile_if.pix_top_right <= next_tile.top_right;
                    tile_if.pix_bottom_left <= next_tile.bottom_left;
                    tile_if.pix_bottom_right <= next_tile.bottom_right;
                    tile_if.inside_mask <= next_tile.mask;
                    tile_if.valid <= 1'b1;
                end
                else
                    tile_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_if.ready <= 1'b0;
        else
        begin
            if (cell_if.valid && cell_if.ready)
            begin
                if (expected_cells.size() == 0)
                begin
                    $display("%0t: cell request with no tile outstanding, expected none, actual pattern %0h",
                             $time, cell_if.pattern);
                    errors++;
                end
                else
                begin
                    oldest_cell = expected_cells.pop_front();
                    check_field("pattern", oldest_cell.pattern, cell_if.pattern);
                    check_field("glyph_code", oldest_cell.glyph, cell_if.glyph_code);
                    check_field("ink_red", oldest_cell.ink.red, cell_if.ink_red);
                    check_field("ink_green", oldest_cell.ink.green, cell_if.ink_green);
                    check_field("ink_blue", oldest_cell.ink.blue, cell_if.ink_blue);
                    check_field("paper_red", oldest_cell.paper.red, cell_if.paper_red);
                    check_field("paper_green", oldest_cell.paper.green, cell_if.paper_green);
                    check_field("paper_blue", oldest_cell.paper.blue, cell_if.paper_blue);
                end
            end
            cell_if.ready <= !receiver_hold && ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    initial
    begin : stimulus
        logic [PIX_W-1:0] px [NUM_PIX];
        color_t           fill_plan [NUM_CHUNKS];
        int               i;
        int               j;
        int               chunk;
        @(posedge rst_n);
        @(negedge clk);

        // Fill is still black from reset here.
        pending_tiles.push_back('{32'h0, 32'h0, 32'h0, 32'h0, 4'h0});
        pending_tiles.push_back('{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                  MASK_ALL});
        // Light first representative: the pattern comes out inverted.
        pending_tiles.push_back('{opaque(255, 255, 255), opaque(0, 0, 0), opaque(0, 0, 0),
                                  opaque(0, 0, 0), MASK_ALL});
        pending_tiles.push_back('{opaque(0, 0, 0), opaque(255, 255, 255),
                                  opaque(255, 255, 255), opaque(255, 255, 255), MASK_ALL});
        // Different colors with the same truncated luma.
        pending_tiles.push_back('{opaque(255, 0, 0), opaque(0, 130, 0), opaque(255, 0, 0),
                                  opaque(255, 0, 0), MASK_ALL});
        pending_tiles.push_back('{opaque(1, 0, 0), opaque(0, 0, 0), opaque(0, 0, 0),
                                  opaque(1, 0, 0), MASK_ALL});
        // Bottom pixels sit exactly halfway between the two representatives.
        pending_tiles.push_back('{opaque(0, 0, 0), opaque(200, 0, 0), opaque(100, 0, 0),
                                  opaque(100, 0, 0), MASK_ALL});
        // Alpha of one is opaque, alpha of zero falls back to the fill.
        pending_tiles.push_back('{32'h01FFFFFF, 32'h01808080, 32'h00FFFFFF, 32'h00FFFFFF,
                                  MASK_ALL});
        pending_tiles.push_back('{opaque(255, 255, 255), opaque(255, 255, 255),
                                  opaque(40, 90, 200), opaque(40, 90, 200), 4'h5});
        pending_tiles.push_back('{opaque(255, 255, 255), opaque(255, 255, 255),
                                  opaque(40, 90, 200), opaque(40, 90, 200), 4'hA});
        pending_tiles.push_back('{opaque(255, 0, 255), opaque(0, 255, 0),
                                  opaque(255, 255, 0), opaque(0, 0, 255), MASK_ALL});
        // Each of the six pairs in turn is the unique farthest one.
        for (i = 0; i < NUM_PIX; i++)
            for (j = i + 1; j < NUM_PIX; j++)
            begin
                px = '{default: opaque(128, 128, 128)};
                px[i] = opaque(0, 0, 0);
                px[j] = opaque(255, 255, 255);
                pending_tiles.push_back('{px[0], px[1], px[2], px[3], MASK_ALL});
                px[i] = opaque(255, 255, 255);
                px[j] = opaque(0, 0, 0);
                pending_tiles.push_back('{px[0], px[1], px[2], px[3], MASK_ALL});
            end

        fill_plan[0] = '{8'hFF, 8'hFF, 8'hFF};
        fill_plan[1] = '{8'h00, 8'h00, 8'h00};
        fill_plan[2] = '{8'hFF, 8'h00, 8'h80};
        fill_plan[3] = color_t'($urandom);
        fill_plan[4] = '{8'h01, 8'hFE, 8'h7F};
        fill_plan[5] = color_t'($urandom);

        for (chunk = 0; chunk < NUM_CHUNKS; chunk++)
        begin
            wait_idle();
            write_fill(fill_plan[chunk], chunk == 0 || chunk == 3);
            @(negedge clk);
            if (chunk < 2)
            begin
                sender_idle_pct = 15;
                receiver_idle_pct = 46;
            end
            else if (chunk < 4)
            begin
                sender_idle_pct = 46;
                receiver_idle_pct = 15;
            end
            else
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            for (i = 0; i < CHUNK_TILES; i++)
                pending_tiles.push_back(random_tile());
        end
        wait_idle();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
